[sv/half_perimeter_wirelength_defines.svh]
// Assertion macros used by the half-perimeter wirelength checker.
`ifndef HALF_PERIMETER_WIRELENGTH_DEFINES_SVH
`define HALF_PERIMETER_WIRELENGTH_DEFINES_SVH

// Same-cycle implication, clocked on aclk and disabled while aresetn is low.
`define HPWL_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on aclk and disabled while aresetn is low.
`define HPWL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/hpwl_pkg.sv]
// Types, widths and constants of the half-perimeter wirelength block.
`default_nettype none
package hpwl_pkg;

    localparam int unsigned CELL_COUNT = 4096;
    localparam int ADDR_BITS  = $clog2(CELL_COUNT);
    localparam int IDX_BITS   = 12;
    localparam int COORD_BITS = 31;
    localparam int PIN_BITS   = COORD_BITS + 1;
    localparam int LEN_BITS   = PIN_BITS + 1;
    localparam int TOTAL_BITS = 48;

    // Input beat layout.
    localparam int S_X_LSB      = IDX_BITS;
    localparam int S_Y_LSB      = IDX_BITS + COORD_BITS;
    localparam int S_DATA_USED  = IDX_BITS + 2 * COORD_BITS;
    localparam int S_TDATA_BITS = ((S_DATA_USED + 7) / 8) * 8;
    localparam int S_TUSER_BITS = 2;
    localparam int S_CMD_BIT    = 0;
    localparam int S_LNET_BIT   = 1;

    // Output beat layout.
    localparam int M_NET_LSB    = 4 * PIN_BITS;
    localparam int M_TOTAL_LSB  = M_NET_LSB + LEN_BITS;
    localparam int M_DATA_USED  = M_TOTAL_LSB + TOTAL_BITS;
    localparam int M_TDATA_BITS = ((M_DATA_USED + 7) / 8) * 8;
    localparam int M_PAD_BITS   = M_TDATA_BITS - M_DATA_USED;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_PIN  = 1'b1
    } cmd_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PIN_BITS-1:0]   pin_t;
    typedef logic        [ADDR_BITS-1:0]  addr_t;
    typedef logic        [LEN_BITS-1:0]   len_t;
    typedef logic        [TOTAL_BITS-1:0] total_t;

    typedef struct packed {
        coord_t y;
        coord_t x;
    } cell_pos_t;

    // x_low sits in the lowest bits so the struct drops straight into tdata.
    typedef struct packed {
        pin_t y_high;
        pin_t y_low;
        pin_t x_high;
        pin_t x_low;
    } box_t;

    typedef struct packed {
        logic      wr_en;
        logic      rd_en;
        addr_t     addr;
        cell_pos_t wr_data;
    } store_req_t;

    localparam pin_t   PIN_MAX   = {1'b0, {(PIN_BITS-1){1'b1}}};
    localparam pin_t   PIN_MIN   = {1'b1, {(PIN_BITS-1){1'b0}}};
    localparam total_t TOTAL_MAX = {TOTAL_BITS{1'b1}};

    localparam box_t BOX_EMPTY = '{
        y_high: PIN_MIN,
        y_low:  PIN_MAX,
        x_high: PIN_MIN,
        x_low:  PIN_MAX
    };

endpackage
`default_nettype wire

[sv/hpwl_store.sv]
// Cell position memory: per cycle one write and one registered read, both at req.addr.
`default_nettype none
module hpwl_store (
    input  wire logic                  aclk,
    input  wire hpwl_pkg::store_req_t  req,
    output hpwl_pkg::cell_pos_t        rd_data
);

    hpwl_pkg::cell_pos_t pos_mem [hpwl_pkg::CELL_COUNT];
    hpwl_pkg::cell_pos_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            pos_mem[req.addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= pos_mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

[sv/half_perimeter_wirelength.sv]
// Half-perimeter wirelength evaluator: cell store, running box and length total.
//
// Input stream (s_axis): one beat is a cell load (tuser[0] = 0) or one pin of a
// net (tuser[0] = 1). tdata carries cell_index, x_value, y_value; tlast marks the
// last pin of a net and tuser[1] the last net. A load writes the cell memory at
// once, so a pin in the very next beat already sees the new position.
// Output stream (m_axis): one beat per finished net with its bounding box, its
// half-perimeter and the saturating running total; tlast marks the last net,
// after which the total restarts from zero.
// Throughput is one beat per cycle while the receiver does not stall. After its
// last pin is accepted, a net's result passes the memory read, box update and
// span sum, then the total adder feeding the output register, to reach m_axis.
// When the receiver stalls, results collect in the pipeline stages and
// s_axis_tready drops only once the pin stage cannot move on.
// Reset clears the pipeline, the running box and the total; the cell memory
// is not cleared and a pin must only name cells loaded since reset.
`default_nettype none
module half_perimeter_wirelength (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // cell_index, x_value, y_value, zero padding
    input  wire logic [hpwl_pkg::S_TDATA_BITS-1:0]     s_axis_tdata,
    // cmd, last_net
    input  wire logic [hpwl_pkg::S_TUSER_BITS-1:0]     s_axis_tuser,
    input  wire logic                                   s_axis_tlast,
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // box_x_low, box_x_high, box_y_low, box_y_high, net_length, total_length,
    // zero padding
    output logic      [hpwl_pkg::M_TDATA_BITS-1:0]     m_axis_tdata,
    output logic                                        m_axis_tlast
);

    logic [hpwl_pkg::IDX_BITS-1:0] in_idx;
    hpwl_pkg::coord_t              in_x;
    hpwl_pkg::coord_t              in_y;
    hpwl_pkg::cmd_t                in_cmd;
    logic                          in_range;
    logic                          accept;
    logic                          accept_pin;

    hpwl_pkg::store_req_t          store_req;
    hpwl_pkg::cell_pos_t           cell_pos;

    // Pin stage.
    logic                          s1_valid_reg;
    logic                          s1_hit_reg;
    logic                          s1_last_pin_reg;
    logic                          s1_last_net_reg;
    hpwl_pkg::coord_t              s1_x_reg;
    hpwl_pkg::coord_t              s1_y_reg;
    hpwl_pkg::box_t                run_box_reg;
    hpwl_pkg::box_t                box_next;
    hpwl_pkg::coord_t              cell_x;
    hpwl_pkg::coord_t              cell_y;
    hpwl_pkg::pin_t                pin_x;
    hpwl_pkg::pin_t                pin_y;
    logic                          adv1;

    // Finished box stage.
    logic                          s2_valid_reg;
    logic                          s2_last_net_reg;
    hpwl_pkg::box_t                s2_box_reg;
    hpwl_pkg::len_t                net_next;
    logic                          adv2;

    // Span sum stage.
    logic                          s3_valid_reg;
    logic                          s3_last_net_reg;
    hpwl_pkg::box_t                s3_box_reg;
    hpwl_pkg::len_t                s3_net_reg;
    logic                          adv3;

    // Output register and running total.
    logic                          out_valid_reg;
    logic                          out_final_reg;
    hpwl_pkg::box_t                out_box_reg;
    hpwl_pkg::len_t                out_net_reg;
    hpwl_pkg::total_t              out_total_reg;
    hpwl_pkg::total_t              total_reg;
    logic [hpwl_pkg::TOTAL_BITS:0] total_sum;
    hpwl_pkg::total_t              total_next;

    assign in_idx   = s_axis_tdata[hpwl_pkg::IDX_BITS-1:0];
    assign in_x     = s_axis_tdata[hpwl_pkg::S_Y_LSB-1:hpwl_pkg::S_X_LSB];
    assign in_y     = s_axis_tdata[hpwl_pkg::S_DATA_USED-1:hpwl_pkg::S_Y_LSB];
    assign in_cmd   = hpwl_pkg::cmd_t'(s_axis_tuser[hpwl_pkg::S_CMD_BIT]);
    assign in_range = 32'(in_idx) < hpwl_pkg::CELL_COUNT;

    // Pipeline advance conditions, from the output backwards.
    assign adv3 = s3_valid_reg && (!out_valid_reg || m_axis_tready);
    assign adv2 = s2_valid_reg && (!s3_valid_reg || adv3);
    assign adv1 = s1_valid_reg && (!s1_last_pin_reg || !s2_valid_reg || adv2);

    assign s_axis_tready = !s1_valid_reg || adv1;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign accept_pin    = accept && (in_cmd == hpwl_pkg::CMD_PIN);

    always_comb begin
        store_req.wr_en     = accept && (in_cmd == hpwl_pkg::CMD_LOAD) && in_range;
        store_req.rd_en     = accept_pin;
        store_req.addr      = hpwl_pkg::ADDR_BITS'(in_idx);
        store_req.wr_data.x = in_x;
        store_req.wr_data.y = in_y;
    end

    hpwl_store u_store (
        .aclk    (aclk),
        .req     (store_req),
        .rd_data (cell_pos)
    );

    // A pin beyond the cell range sits on a cell at the origin.
    assign cell_x = s1_hit_reg ? cell_pos.x : '0;
    assign cell_y = s1_hit_reg ? cell_pos.y : '0;
    assign pin_x  = hpwl_pkg::PIN_BITS'(cell_x) + hpwl_pkg::PIN_BITS'(s1_x_reg);
    assign pin_y  = hpwl_pkg::PIN_BITS'(cell_y) + hpwl_pkg::PIN_BITS'(s1_y_reg);

    always_comb begin
        box_next = run_box_reg;
        if ($signed(pin_x) < $signed(run_box_reg.x_low)) begin
            box_next.x_low = pin_x;
        end
        if ($signed(pin_x) > $signed(run_box_reg.x_high)) begin
            box_next.x_high = pin_x;
        end
        if ($signed(pin_y) < $signed(run_box_reg.y_low)) begin
            box_next.y_low = pin_y;
        end
        if ($signed(pin_y) > $signed(run_box_reg.y_high)) begin
            box_next.y_high = pin_y;
        end
    end

    // Both spans are non-negative and below 2^32, so the wrapped differences are exact.
    assign net_next =
        hpwl_pkg::LEN_BITS'($unsigned(s2_box_reg.x_high - s2_box_reg.x_low)) +
        hpwl_pkg::LEN_BITS'($unsigned(s2_box_reg.y_high - s2_box_reg.y_low));

    assign total_sum  = (hpwl_pkg::TOTAL_BITS+1)'(total_reg) +
                        (hpwl_pkg::TOTAL_BITS+1)'(s3_net_reg);
    assign total_next = total_sum[hpwl_pkg::TOTAL_BITS] ?
                        hpwl_pkg::TOTAL_MAX : total_sum[hpwl_pkg::TOTAL_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            run_box_reg   <= hpwl_pkg::BOX_EMPTY;
            total_reg     <= '0;
        end else begin
            if (accept_pin) begin
                s1_valid_reg <= 1'b1;
            end else if (adv1) begin
                s1_valid_reg <= 1'b0;
            end

            if (adv1) begin
                run_box_reg <= s1_last_pin_reg ? hpwl_pkg::BOX_EMPTY : box_next;
            end

            if (adv1 && s1_last_pin_reg) begin
                s2_valid_reg <= 1'b1;
            end else if (adv2) begin
                s2_valid_reg <= 1'b0;
            end

            if (adv2) begin
                s3_valid_reg <= 1'b1;
            end else if (adv3) begin
                s3_valid_reg <= 1'b0;
            end

            if (adv3) begin
                out_valid_reg <= 1'b1;
                total_reg     <= s3_last_net_reg ? '0 : total_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_pin) begin
            s1_hit_reg      <= in_range;
            s1_last_pin_reg <= s_axis_tlast;
            s1_last_net_reg <= s_axis_tuser[hpwl_pkg::S_LNET_BIT];
            s1_x_reg        <= in_x;
            s1_y_reg        <= in_y;
        end
        if (adv1 && s1_last_pin_reg) begin
            s2_box_reg      <= box_next;
            s2_last_net_reg <= s1_last_net_reg;
        end
        if (adv2) begin
            s3_box_reg      <= s2_box_reg;
            s3_net_reg      <= net_next;
            s3_last_net_reg <= s2_last_net_reg;
        end
        if (adv3) begin
            out_box_reg   <= s3_box_reg;
            out_net_reg   <= s3_net_reg;
            out_total_reg <= total_next;
            out_final_reg <= s3_last_net_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_final_reg;
    assign m_axis_tdata  = {{hpwl_pkg::M_PAD_BITS{1'b0}}, out_total_reg, out_net_reg,
                            out_box_reg};

endmodule
`default_nettype wire

[sv/hpwl_checker.sv]
// Port-level checks on the half-perimeter wirelength block, bound to its top level.
`default_nettype none
`include "half_perimeter_wirelength_defines.svh"
module hpwl_checker (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [hpwl_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
    input wire logic [hpwl_pkg::S_TUSER_BITS-1:0]  s_axis_tuser,
    input wire logic                                s_axis_tlast,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [hpwl_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
    input wire logic                                m_axis_tlast
);

    hpwl_pkg::box_t   box_w;
    hpwl_pkg::len_t   net_w;
    hpwl_pkg::total_t total_w;
    hpwl_pkg::len_t   span_sum;
    logic             box_ordered;
    logic             in_seen;

    assign box_w   = m_axis_tdata[hpwl_pkg::M_NET_LSB-1:0];
    assign net_w   = m_axis_tdata[hpwl_pkg::M_TOTAL_LSB-1:hpwl_pkg::M_NET_LSB];
    assign total_w = m_axis_tdata[hpwl_pkg::M_DATA_USED-1:hpwl_pkg::M_TOTAL_LSB];

    assign span_sum =
        hpwl_pkg::LEN_BITS'($unsigned(box_w.x_high - box_w.x_low)) +
        hpwl_pkg::LEN_BITS'($unsigned(box_w.y_high - box_w.y_low));
    assign box_ordered = ($signed(box_w.x_low) <= $signed(box_w.x_high)) &&
                         ($signed(box_w.y_low) <= $signed(box_w.y_high));

    // Input side is observed only so the checker can bind by name.
    assign in_seen = s_axis_tvalid && s_axis_tready && s_axis_tlast &&
                     (s_axis_tdata != '0) && (s_axis_tuser != '0);

    `HPWL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result beat dropped while stalled")
    `HPWL_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")
    `HPWL_ASSERT(a_box_order, m_axis_tvalid, box_ordered, "bounding box low exceeds high")
    `HPWL_ASSERT(a_net_len, m_axis_tvalid, net_w == span_sum, "net length is not the sum of the spans")
    `HPWL_ASSERT(a_total_ge, m_axis_tvalid || in_seen, !m_axis_tvalid || (total_w >= hpwl_pkg::TOTAL_BITS'(net_w)), "running total below net length")

endmodule

bind half_perimeter_wirelength hpwl_checker u_hpwl_checker (.*);
`default_nettype wire

[test/tb_half_perimeter_wirelength.sv]
// Self-checking testbench for the half-perimeter wirelength evaluator.
`timescale 1ns / 100ps
module tb_half_perimeter_wirelength;

    localparam hpwl_pkg::coord_t COORD_HI = {1'b0, {(hpwl_pkg::COORD_BITS-1){1'b1}}};
    localparam hpwl_pkg::coord_t COORD_LO = {1'b1, {(hpwl_pkg::COORD_BITS-1){1'b0}}};
    localparam hpwl_pkg::addr_t  CELL_FIRST = '0;
    localparam hpwl_pkg::addr_t  CELL_LAST  = '1;

    typedef struct {
        hpwl_pkg::box_t   box;
        hpwl_pkg::len_t   net_len;
        hpwl_pkg::total_t total;
        logic             is_final;
    } net_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_axis_tvalid;
    logic                              s_axis_tready;
    // cell_index, x_value, y_value, zero padding
    logic [hpwl_pkg::S_TDATA_BITS-1:0] s_axis_tdata;
    // cmd, last_net
    logic [hpwl_pkg::S_TUSER_BITS-1:0] s_axis_tuser;
    logic                              s_axis_tlast;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready;
    // box_x_low, box_x_high, box_y_low, box_y_high, net_length, total_length,
    // zero padding
    logic [hpwl_pkg::M_TDATA_BITS-1:0] m_axis_tdata;
    logic                              m_axis_tlast;

    // Predictor state: cell positions, the open net's box and the length total.
    hpwl_pkg::coord_t cell_x [hpwl_pkg::CELL_COUNT];
    hpwl_pkg::coord_t cell_y [hpwl_pkg::CELL_COUNT];
    bit               cell_known [hpwl_pkg::CELL_COUNT];
    hpwl_pkg::addr_t  known_cells[$];
    hpwl_pkg::box_t   open_box = hpwl_pkg::BOX_EMPTY;
    hpwl_pkg::total_t run_total = '0;
    net_result_t      expected_nets[$];

    int mismatch_count = 0;
    int idle_pct = 25;
    int hold_left = 0;

    half_perimeter_wirelength dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic predict_beat(hpwl_pkg::cmd_t cmd, hpwl_pkg::addr_t idx,
                                hpwl_pkg::coord_t xv, hpwl_pkg::coord_t yv,
                                logic last_pin, logic last_net);
        hpwl_pkg::pin_t                px;
        hpwl_pkg::pin_t                py;
        logic [hpwl_pkg::PIN_BITS-1:0] x_span;
        logic [hpwl_pkg::PIN_BITS-1:0] y_span;
        logic [hpwl_pkg::TOTAL_BITS:0] sum;
        net_result_t                   res;
        if (cmd == hpwl_pkg::CMD_LOAD) begin
            if (!cell_known[idx]) begin
                cell_known[idx] = 1'b1;
                known_cells.push_back(idx);
            end
            cell_x[idx] = xv;
            cell_y[idx] = yv;
            return;
        end
        // Both operands are signed, so they are sign-extended to pin width.
        px = cell_x[idx] + xv;
        py = cell_y[idx] + yv;
        if (px < open_box.x_low) open_box.x_low = px;
        if (px > open_box.x_high) open_box.x_high = px;
        if (py < open_box.y_low) open_box.y_low = py;
        if (py > open_box.y_high) open_box.y_high = py;
        if (!last_pin) return;
        x_span = open_box.x_high - open_box.x_low;
        y_span = open_box.y_high - open_box.y_low;
        res.box = open_box;
        res.net_len = hpwl_pkg::len_t'(x_span) + hpwl_pkg::len_t'(y_span);
        sum = run_total + res.net_len;
        run_total = sum[hpwl_pkg::TOTAL_BITS] ? hpwl_pkg::TOTAL_MAX :
                    sum[hpwl_pkg::TOTAL_BITS-1:0];
        res.total = run_total;
        res.is_final = last_net;
        expected_nets.push_back(res);
        open_box = hpwl_pkg::BOX_EMPTY;
        if (last_net) run_total = '0;
    endtask

    task automatic send_beat(hpwl_pkg::cmd_t cmd, hpwl_pkg::addr_t idx,
                             hpwl_pkg::coord_t xv, hpwl_pkg::coord_t yv,
                             logic last_pin, logic last_net);
        logic [hpwl_pkg::S_TDATA_BITS-1:0] beat;
        logic [hpwl_pkg::S_TUSER_BITS-1:0] user;
        beat = '0;
        beat[hpwl_pkg::IDX_BITS-1:0] = idx;
        beat[hpwl_pkg::S_X_LSB +: hpwl_pkg::COORD_BITS] = xv;
        beat[hpwl_pkg::S_Y_LSB +: hpwl_pkg::COORD_BITS] = yv;
        user = '0;
        user[hpwl_pkg::S_CMD_BIT] = cmd;
        user[hpwl_pkg::S_LNET_BIT] = last_net;
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= beat;
        s_axis_tuser <= user;
        s_axis_tlast <= last_pin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        predict_beat(cmd, idx, xv, yv, last_pin, last_net);
    endtask

    function automatic hpwl_pkg::coord_t random_coord();
        case ($urandom_range(7))
            0: return COORD_LO;
            1: return COORD_HI;
            2: return hpwl_pkg::coord_t'($urandom_range(32)) - hpwl_pkg::coord_t'(16);
            default: return hpwl_pkg::coord_t'($urandom);
        endcase
    endfunction

    function automatic hpwl_pkg::addr_t random_known_cell();
        return known_cells[$urandom_range(known_cells.size() - 1)];
    endfunction

    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    initial begin : result_checker
        net_result_t    want;
        hpwl_pkg::box_t got_box;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                if (expected_nets.size() == 0) begin
                    $error("Result beat arrived with no finished net outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_nets.pop_front();
                    got_box = m_axis_tdata[4*hpwl_pkg::PIN_BITS-1:0];
                    check_field("box_x_low", want.box.x_low, got_box.x_low);
                    check_field("box_x_high", want.box.x_high, got_box.x_high);
                    check_field("box_y_low", want.box.y_low, got_box.y_low);
                    check_field("box_y_high", want.box.y_high, got_box.y_high);
                    check_field("net_length", want.net_len,
                                m_axis_tdata[hpwl_pkg::M_NET_LSB +: hpwl_pkg::LEN_BITS]);
                    check_field("total_length", want.total,
                                m_axis_tdata[hpwl_pkg::M_TOTAL_LSB +: hpwl_pkg::TOTAL_BITS]);
                    check_field("is_final", want.is_final, m_axis_tlast);
                    check_field("padding", '0,
                                m_axis_tdata[hpwl_pkg::M_TDATA_BITS-1:hpwl_pkg::M_DATA_USED]);
                end
            end
        end
    end

    // The receiver stalls at random, or for a whole stretch when one is requested.
    initial begin : result_receiver
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic test_directed_cases();
        // Flags on a load are ignored.
        send_beat(hpwl_pkg::CMD_LOAD, CELL_FIRST, COORD_LO, COORD_LO, 1'b1, 1'b1);
        send_beat(hpwl_pkg::CMD_LOAD, CELL_LAST, COORD_HI, COORD_HI, 1'b0, 1'b0);
        send_beat(hpwl_pkg::CMD_LOAD, 12'h555, 31'h2AAAAAAA, 31'h55555555, 1'b0, 1'b0);
        // Single-pin net at the most negative pin position.
        send_beat(hpwl_pkg::CMD_PIN, CELL_FIRST, COORD_LO, COORD_LO, 1'b1, 1'b0);
        // Widest possible net; last_net on a pin that does not close the net is ignored.
        send_beat(hpwl_pkg::CMD_PIN, CELL_FIRST, COORD_LO, COORD_LO, 1'b0, 1'b1);
        send_beat(hpwl_pkg::CMD_PIN, CELL_LAST, COORD_HI, COORD_HI, 1'b1, 1'b0);
        // A pin right after a load must see the new position.
        send_beat(hpwl_pkg::CMD_LOAD, 12'hAAA, -31'sd12345, 31'sd67890, 1'b0, 1'b0);
        send_beat(hpwl_pkg::CMD_PIN, 12'hAAA, '0, '0, 1'b1, 1'b0);
        send_beat(hpwl_pkg::CMD_LOAD, 12'hAAA, 31'h15555555, 31'h6AAAAAAA, 1'b0, 1'b0);
        send_beat(hpwl_pkg::CMD_PIN, 12'hAAA, 31'sd3, -31'sd9, 1'b0, 1'b0);
        send_beat(hpwl_pkg::CMD_PIN, 12'h555, COORD_HI, COORD_LO, 1'b1, 1'b1);
        // The total starts again from zero after the last net.
        send_beat(hpwl_pkg::CMD_PIN, 12'h555, '0, '0, 1'b0, 1'b0);
        send_beat(hpwl_pkg::CMD_PIN, 12'h555, 31'sd5, -31'sd7, 1'b1, 1'b0);
        send_beat(hpwl_pkg::CMD_PIN, CELL_LAST, COORD_LO, COORD_HI, 1'b1, 1'b1);
    endtask

    task automatic send_random_traffic(int item_goal);
        int sent;
        int pins;
        int roll;
        sent = 0;
        while (sent < item_goal) begin
            roll = $urandom_range(99);
            if (roll < 12) begin
                send_beat(hpwl_pkg::CMD_LOAD, hpwl_pkg::addr_t'($urandom), random_coord(),
                          random_coord(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                sent++;
            end else if (roll < 16) begin
                // A stray pin flagged as the last net without closing the net.
                send_beat(hpwl_pkg::CMD_PIN, random_known_cell(), random_coord(),
                          random_coord(), 1'b0, 1'b1);
                sent++;
            end else begin
                pins = $urandom_range(1, 6);
                for (int i = 0; i < pins; i++) begin
                    if (i == pins - 1)
                        send_beat(hpwl_pkg::CMD_PIN, random_known_cell(), random_coord(),
                                  random_coord(), 1'b1, ($urandom_range(9) == 0));
                    else
                        send_beat(hpwl_pkg::CMD_PIN, random_known_cell(), random_coord(),
                                  random_coord(), 1'b0, 1'($urandom_range(1)));
                end
                sent += pins;
            end
        end
    endtask

    task automatic test_random_traffic();
        send_random_traffic(270);
    endtask

    task automatic test_full_rate();
        idle_pct = 0;
        send_random_traffic(100);
        idle_pct = 25;
    endtask

    // Every beat closes a net while the receiver holds off, so the pipeline
    // fills and the input must stall.
    task automatic test_output_stall();
        hold_left = 300;
        for (int i = 0; i < 60; i++)
            send_beat(hpwl_pkg::CMD_PIN, random_known_cell(), random_coord(), random_coord(),
                      1'b1, ($urandom_range(19) == 0));
    endtask

    initial begin
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        s_axis_tlast <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_random_traffic();
        test_full_rate();
        test_output_stall();
        s_axis_tvalid <= 1'b0;
        while (expected_nets.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[files.f]
+incdir+sv
sv/hpwl_pkg.sv
sv/hpwl_store.sv
sv/half_perimeter_wirelength.sv
sv/hpwl_checker.sv
test/tb_half_perimeter_wirelength.sv
